FILE: rtl/core/keyframe_track_interpolator_macros.svh
// assertion macros for the keyframe track interpolator
`ifndef KEYFRAME_TRACK_INTERPOLATOR_MACROS_SVH
`define KEYFRAME_TRACK_INTERPOLATOR_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked on every rising edge outside reset
`define KTI_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("kti assertion failed");

// next-cycle implication
`define KTI_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("kti assertion failed");

`else

`define KTI_ASSERT_IMP(lbl, ante, cons)
`define KTI_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

FILE: rtl/core/kti_pkg.sv
// shared types and codes of the keyframe track interpolator
`default_nettype none

package kti_pkg;

    // divider width and step counter width
    localparam int DIV_W  = 33;
    localparam int STEP_W = 6;

    // configuration register indexes
    localparam logic [2:0] CFG_FREQUENCY  = 3'd0;
    localparam logic [2:0] CFG_PHASE      = 3'd1;
    localparam logic [2:0] CFG_START_TIME = 3'd2;
    localparam logic [2:0] CFG_STOP_TIME  = 3'd3;
    localparam logic [2:0] CFG_EXTRAP     = 3'd4;
    localparam logic [2:0] CFG_INTERP     = 3'd5;
    localparam logic [2:0] CFG_KEY_COUNT  = 3'd6;

    // extrapolation codes
    localparam logic [1:0] EXT_CYCLIC   = 2'd0;
    localparam logic [1:0] EXT_REVERSE  = 2'd1;

    // interpolation codes
    localparam logic [1:0] INTERP_HERMITE = 2'd1;
    localparam logic [1:0] INTERP_STEP    = 2'd2;

    // input word kinds
    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef struct packed {
        logic               kind;
        logic [5:0]         key_index;
        logic signed [31:0] key_time;
        logic signed [31:0] key_value;
        logic signed [31:0] key_forward;
        logic signed [31:0] key_backward;
        logic signed [31:0] query_time;
    } t_kti_in;

    typedef struct packed {
        logic signed [31:0] result_value;
        logic               result_valid;
        logic signed [31:0] mapped_time;
        logic [5:0]         lower_key;
    } t_kti_out;

    typedef struct packed {
        logic              start;
        logic [STEP_W-1:0] steps;
        logic [DIV_W-1:0]  rem_init;
        logic [DIV_W-1:0]  dividend;
        logic [DIV_W-1:0]  divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quo;
        logic [DIV_W-1:0] rem;
    } t_div_rsp;

endpackage

`default_nettype wire

FILE: rtl/core/keyframe_track_interpolator.sv
// top level: key store, time mapping, key search and value evaluation
// A key write word is stored while the block is idle. A query word runs
// through a sequencer around one key memory (single read port, registered
// read): time scaling, a division when cyclic or reverse wrapping applies,
// checks of the end keys and the hint, a walk from the hint key by key, a
// division for the segment fraction when it needs the divider, a fetch of
// both keys, then the linear, stepped or Hermite (one shared multiplier)
// evaluation, and the hand-over of the result word. The next word is taken
// once the result has moved into the output register.
`default_nettype none

module keyframe_track_interpolator #(
    parameter int MAX_KEYS  = 64,
    parameter int FRAC_BITS = 16
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_in_valid,
    output logic              o_in_ready,
    input  kti_pkg::t_kti_in  i_in_word,
    output logic              o_out_valid,
    input  wire               i_out_ready,
    output kti_pkg::t_kti_out o_out_word,
    input  wire               i_cfg_valid,
    output logic              o_cfg_ready,
    input  wire [2:0]         i_cfg_index,
    input  wire [31:0]        i_cfg_data
);
    import kti_pkg::*;

    `include "keyframe_track_interpolator_macros.svh"

    localparam int AW = $clog2(MAX_KEYS);
    localparam int CW = $clog2(MAX_KEYS + 1);
    localparam int XW = FRAC_BITS + 1;
    localparam int BW = FRAC_BITS + 4;
    localparam int SW = 66 - FRAC_BITS;
    localparam int HW = 68 - FRAC_BITS;
    localparam logic [XW-1:0] X_ONE  = XW'(1) << FRAC_BITS;
    localparam logic [XW-1:0] X_HALF = XW'(1) << (FRAC_BITS - 1);

    typedef enum logic [4:0] {
        S_IDLE, S_MUL, S_MAP, S_WRAP, S_K0, S_KN, S_KI, S_CMPI, S_FWD, S_BWD,
        S_FRAC, S_FDIV, S_LO, S_HI, S_CALC, S_LIN, S_LIN2,
        S_H1, S_H2, S_H3, S_H4, S_H5, S_H6, S_H7, S_H8, S_H9, S_DONE
    } t_state;

    // configuration
    logic signed [31:0] r_freq, r_phase, r_start, r_stop;
    logic [1:0]         r_ext, r_interp;
    logic [CW-1:0]      r_count;

    // sequencer state
    t_state             r_state;
    logic [AW-1:0]      r_hint;
    logic signed [31:0] r_raw, r_t, r_ti, r_v1, r_v2, r_tb, r_tf, r_val;
    logic               r_dneg, r_bwd, r_res_valid;
    logic [32:0]        r_delta;
    logic [AW-1:0]      r_i, r_j, r_lo, r_hi;
    logic signed [32:0] r_num, r_den;
    logic [XW-1:0]      r_x, r_x2, r_x3;
    logic signed [64:0] r_prod;
    logic signed [67:0] r_acc;
    logic               r_out_valid;
    t_kti_out           r_out;

    // key memory: time, value, forward tangent, backward tangent
    logic [127:0]       mem [MAX_KEYS];
    logic [127:0]       r_rdata;
    logic [AW-1:0]      rd_addr;
    logic signed [31:0] rd_time, rd_value, rd_fwd, rd_bwd;

    logic               in_fire, key_ok;
    logic [CW-1:0]      n_last;
    logic [AW-1:0]      hint0;
    t_div_req           div_req;
    t_div_rsp           div_rsp;

    logic signed [32:0] mul_a;
    logic signed [31:0] mul_b;
    logic signed [64:0] mul_p;

    logic signed [64-FRAC_BITS:0] prod_hi;
    logic signed [31:0]           sum_b;
    logic signed [SW-1:0]         sum;
    logic signed [31:0]           sum_sat;
    logic signed [HW-1:0]         acc_sh;
    logic signed [31:0]           acc_sat;
    logic signed [32:0]           delta33, d33;
    logic [32:0]                  abs_d;
    logic                         in_rng, wrap_mode, map_wrap;
    logic signed [31:0]           clamp_t, wrap_t;
    logic [32:0]                  wrap_r;
    logic                         wrap_odd;
    logic signed [BW-1:0]         xs, x2s, x3s, b0, b1, b2, b3;
    logic                         frac_zero, frac_full;
    logic [XW-1:0]                frac_div;
    logic                         fwd_go, bwd_go;

    assign in_fire     = i_in_valid && o_in_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;
    assign key_ok      = (32'(i_in_word.key_index) < 32'(MAX_KEYS));
    assign n_last      = r_count - 1'b1;
    assign hint0       = (CW'(r_hint) < r_count) ? r_hint : '0;

    assign rd_time  = signed'(r_rdata[127:96]);
    assign rd_value = signed'(r_rdata[95:64]);
    assign rd_fwd   = signed'(r_rdata[63:32]);
    assign rd_bwd   = signed'(r_rdata[31:0]);

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_freq   <= 32'sh0001_0000;
            r_phase  <= '0;
            r_start  <= '0;
            r_stop   <= '0;
            r_ext    <= 2'd2;
            r_interp <= '0;
            r_count  <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_FREQUENCY:  r_freq   <= signed'(i_cfg_data);
                CFG_PHASE:      r_phase  <= signed'(i_cfg_data);
                CFG_START_TIME: r_start  <= signed'(i_cfg_data);
                CFG_STOP_TIME:  r_stop   <= signed'(i_cfg_data);
                CFG_EXTRAP:     r_ext    <= i_cfg_data[1:0];
                CFG_INTERP:     r_interp <= i_cfg_data[1:0];
                CFG_KEY_COUNT:  r_count  <= (32'(i_cfg_data[6:0]) > 32'(MAX_KEYS)) ?
                                            CW'(MAX_KEYS) : CW'(i_cfg_data[6:0]);
                default: ;
            endcase
        end
    end

    // key memory write on a key word, read every cycle
    always_ff @(posedge i_clk) begin
        if (in_fire && (i_in_word.kind == KIND_WRITE) && key_ok) begin
            mem[AW'(i_in_word.key_index)] <= {i_in_word.key_time, i_in_word.key_value,
                                              i_in_word.key_forward, i_in_word.key_backward};
        end
        r_rdata <= mem[rd_addr];
    end

    // shared multiplier, product registered
    assign mul_p = mul_a * mul_b;
    always_ff @(posedge i_clk) begin
        r_prod <= mul_p;
    end

    // hermite basis from the registered powers of x
    always_comb begin
        xs  = signed'(BW'(r_x));
        x2s = signed'(BW'(r_x2));
        x3s = signed'(BW'(r_x3));
        b0  = (x3s <<< 1) - x2s - (x2s <<< 1) + signed'(BW'(X_ONE));
        b1  = x2s + (x2s <<< 1) - (x3s <<< 1);
        b2  = x3s - (x2s <<< 1) + xs;
        b3  = x3s - x2s;
    end

    // multiplier operand selection
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_MUL: begin
                mul_a = 33'(r_freq);
                mul_b = r_raw;
            end
            S_LIN: begin
                mul_a = 33'(r_v2) - 33'(r_v1);
                mul_b = signed'(32'(r_x));
            end
            S_H1: begin
                mul_a = signed'(33'(r_x));
                mul_b = signed'(32'(r_x));
            end
            S_H2: begin
                mul_a = signed'(33'(r_prod[FRAC_BITS +: XW]));
                mul_b = signed'(32'(r_x));
            end
            S_H4: begin
                mul_a = 33'(r_v1);
                mul_b = 32'(b0);
            end
            S_H5: begin
                mul_a = 33'(r_v2);
                mul_b = 32'(b1);
            end
            S_H6: begin
                mul_a = 33'(r_tb);
                mul_b = 32'(b2);
            end
            S_H7: begin
                mul_a = 33'(r_tf);
                mul_b = 32'(b3);
            end
            default: ;
        endcase
    end

    // shifted product plus phase or lower value, saturated
    always_comb begin
        prod_hi = signed'(r_prod[64:FRAC_BITS]);
        sum_b   = (r_state == S_MAP) ? r_phase : r_v1;
        sum     = SW'(prod_hi) + SW'(sum_b);
        if ((sum[SW-1:31] == '0) || (sum[SW-1:31] == '1)) begin
            sum_sat = sum[31:0];
        end else begin
            sum_sat = sum[SW-1] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end
        acc_sh = signed'(r_acc[67:FRAC_BITS]);
        if ((acc_sh[HW-1:31] == '0) || (acc_sh[HW-1:31] == '1)) begin
            acc_sat = acc_sh[31:0];
        end else begin
            acc_sat = acc_sh[HW-1] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end
    end

    // time mapping: pass-through inside the active range, clamp or wrap outside
    always_comb begin
        in_rng    = (sum_sat >= r_start) && (sum_sat <= r_stop);
        wrap_mode = (r_ext == EXT_CYCLIC) || (r_ext == EXT_REVERSE);
        delta33   = 33'(r_stop) - 33'(r_start);
        d33       = 33'(sum_sat) - 33'(r_start);
        abs_d     = d33[32] ? 33'(-d33) : 33'(d33);
        map_wrap  = !in_rng && wrap_mode && (delta33 > 0);
        if (in_rng) begin
            clamp_t = sum_sat;
        end else if (wrap_mode) begin
            clamp_t = r_start;
        end else if (sum_sat < r_start) begin
            clamp_t = r_start;
        end else begin
            clamp_t = r_stop;
        end
        // floor remainder and period parity
        if (r_dneg && (div_rsp.rem != '0)) begin
            wrap_r   = r_delta - div_rsp.rem;
            wrap_odd = !div_rsp.quo[0];
        end else begin
            wrap_r   = div_rsp.rem;
            wrap_odd = div_rsp.quo[0];
        end
        if ((r_ext == EXT_CYCLIC) || !wrap_odd) begin
            wrap_t = signed'(32'(33'(r_start) + wrap_r));
        end else begin
            wrap_t = signed'(32'(33'(r_stop) - wrap_r));
        end
    end

    // segment fraction shortcuts and key walk decisions
    always_comb begin
        frac_zero = (r_den <= 0) || (r_num <= 0);
        frac_full = (r_num >= r_den);
        frac_div  = XW'(div_rsp.quo);
        fwd_go    = (CW'(r_j) < n_last) && (r_t >= rd_time);
        bwd_go    = (r_j != '0) && (r_t <= rd_time);
    end

    // divider requests
    always_comb begin
        div_req = '0;
        if ((r_state == S_MAP) && map_wrap) begin
            div_req.start    = 1'b1;
            div_req.steps    = STEP_W'(DIV_W);
            div_req.dividend = abs_d;
            div_req.divisor  = 33'(delta33);
        end else if ((r_state == S_FRAC) && !frac_zero && !frac_full) begin
            div_req.start    = 1'b1;
            div_req.steps    = STEP_W'(FRAC_BITS);
            div_req.rem_init = 33'(r_num);
            div_req.divisor  = 33'(r_den);
        end
    end

    kti_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // key memory read address
    always_comb begin
        case (r_state)
            S_KN:    rd_addr = AW'(n_last);
            S_KI:    rd_addr = hint0;
            S_CMPI:  rd_addr = (r_t > rd_time) ? hint0 + 1'b1 : hint0 - 1'b1;
            S_FWD:   rd_addr = r_j + 1'b1;
            S_BWD:   rd_addr = r_j - 1'b1;
            S_LO:    rd_addr = r_lo;
            S_HI:    rd_addr = r_hi;
            default: rd_addr = '0;
        endcase
    end

    // query sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_hint      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_fire && (i_in_word.kind == KIND_QUERY)) begin
                        r_raw   <= i_in_word.query_time;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: r_state <= S_MAP;
                S_MAP: begin
                    r_t     <= clamp_t;
                    r_dneg  <= d33[32];
                    r_delta <= 33'(delta33);
                    r_state <= map_wrap ? S_WRAP : S_K0;
                end
                S_WRAP: begin
                    if (div_rsp.done) begin
                        r_t     <= wrap_t;
                        r_state <= S_K0;
                    end
                end
                S_K0: begin
                    if (r_count == '0) begin
                        r_val       <= '0;
                        r_res_valid <= 1'b0;
                        r_lo        <= '0;
                        r_state     <= S_DONE;
                    end else begin
                        r_res_valid <= 1'b1;
                        r_state     <= S_KN;
                    end
                end
                S_KN: begin
                    if (r_t <= rd_time) begin
                        r_lo    <= '0;
                        r_hi    <= '0;
                        r_x     <= '0;
                        r_state <= S_LO;
                    end else begin
                        r_state <= S_KI;
                    end
                end
                S_KI: begin
                    if (r_t >= rd_time) begin
                        r_lo    <= AW'(n_last);
                        r_hi    <= AW'(n_last);
                        r_x     <= '0;
                        r_state <= S_LO;
                    end else begin
                        r_state <= S_CMPI;
                    end
                end
                S_CMPI: begin
                    r_i  <= hint0;
                    r_ti <= rd_time;
                    if (r_t > rd_time) begin
                        r_j     <= hint0 + 1'b1;
                        r_state <= S_FWD;
                    end else if (r_t < rd_time) begin
                        r_j     <= hint0 - 1'b1;
                        r_state <= S_BWD;
                    end else begin
                        r_lo    <= hint0;
                        r_hi    <= hint0;
                        r_x     <= '0;
                        r_state <= S_LO;
                    end
                end
                S_FWD: begin
                    if (fwd_go) begin
                        r_i  <= r_j;
                        r_ti <= rd_time;
                        r_j  <= r_j + 1'b1;
                    end else begin
                        r_lo    <= r_i;
                        r_hi    <= r_j;
                        r_num   <= 33'(r_t) - 33'(r_ti);
                        r_den   <= 33'(rd_time) - 33'(r_ti);
                        r_bwd   <= 1'b0;
                        r_state <= S_FRAC;
                    end
                end
                S_BWD: begin
                    if (bwd_go) begin
                        r_i  <= r_j;
                        r_ti <= rd_time;
                        r_j  <= r_j - 1'b1;
                    end else begin
                        r_lo    <= r_j;
                        r_hi    <= r_i;
                        r_num   <= 33'(r_ti) - 33'(r_t);
                        r_den   <= 33'(r_ti) - 33'(rd_time);
                        r_bwd   <= 1'b1;
                        r_state <= S_FRAC;
                    end
                end
                S_FRAC: begin
                    if (frac_zero) begin
                        r_x     <= r_bwd ? X_ONE : '0;
                        r_state <= S_LO;
                    end else if (frac_full) begin
                        r_x     <= r_bwd ? '0 : X_ONE;
                        r_state <= S_LO;
                    end else begin
                        r_state <= S_FDIV;
                    end
                end
                S_FDIV: begin
                    if (div_rsp.done) begin
                        r_x     <= r_bwd ? X_ONE - frac_div : frac_div;
                        r_state <= S_LO;
                    end
                end
                S_LO: begin
                    r_hint  <= r_lo;
                    r_state <= S_HI;
                end
                S_HI: begin
                    r_v1    <= rd_value;
                    r_tb    <= rd_bwd;
                    r_state <= S_CALC;
                end
                S_CALC: begin
                    r_v2 <= rd_value;
                    r_tf <= rd_fwd;
                    if (r_interp == INTERP_HERMITE) begin
                        r_state <= S_H1;
                    end else if (r_interp == INTERP_STEP) begin
                        r_val   <= (r_x < X_HALF) ? r_v1 : rd_value;
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_LIN;
                    end
                end
                S_LIN:  r_state <= S_LIN2;
                S_LIN2: begin
                    r_val   <= sum_sat;
                    r_state <= S_DONE;
                end
                S_H1: r_state <= S_H2;
                S_H2: begin
                    r_x2    <= r_prod[FRAC_BITS +: XW];
                    r_state <= S_H3;
                end
                S_H3: begin
                    r_x3    <= r_prod[FRAC_BITS +: XW];
                    r_state <= S_H4;
                end
                S_H4: r_state <= S_H5;
                S_H5: begin
                    r_acc   <= 68'(r_prod);
                    r_state <= S_H6;
                end
                S_H6: begin
                    r_acc   <= r_acc + 68'(r_prod);
                    r_state <= S_H7;
                end
                S_H7: begin
                    r_acc   <= r_acc + 68'(r_prod);
                    r_state <= S_H8;
                end
                S_H8: begin
                    r_acc   <= r_acc + 68'(r_prod);
                    r_state <= S_H9;
                end
                S_H9: begin
                    r_val   <= acc_sat;
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out.result_value <= r_val;
                        r_out.result_valid <= r_res_valid;
                        r_out.mapped_time  <= r_t;
                        r_out.lower_key    <= 6'(r_lo);
                        r_out_valid        <= 1'b1;
                        r_state            <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // checks
    `KTI_ASSERT_IMP(a_div_done_waiting, div_rsp.done, (r_state == S_WRAP) || (r_state == S_FDIV))
    `KTI_ASSERT_IMP(a_empty_result, o_out_valid && !o_out_word.result_valid, (o_out_word.result_value == '0) && (o_out_word.lower_key == '0))
    `KTI_ASSERT_NXT(a_query_starts, in_fire && (i_in_word.kind == KIND_QUERY), r_state == S_MUL)
    `KTI_ASSERT_IMP(a_x_in_unit, r_state == S_LO, r_x <= X_ONE)

endmodule

`default_nettype wire

FILE: rtl/core/kti_div.sv
// restoring divider, one quotient bit per cycle
`default_nettype none

module kti_div (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  kti_pkg::t_div_req i_req,
    output kti_pkg::t_div_rsp o_rsp
);
    import kti_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_cnt;
    logic [DIV_W-1:0]  r_rem;
    logic [DIV_W-1:0]  r_dvd;
    logic [DIV_W-1:0]  r_den;
    logic [DIV_W-1:0]  r_quo;

    logic [DIV_W:0]    shifted;
    logic [DIV_W:0]    diff;
    logic              ge;
    logic [DIV_W-1:0]  n_rem;

    // one trial subtraction
    always_comb begin
        shifted = {r_rem, r_dvd[DIV_W-1]};
        diff    = shifted - {1'b0, r_den};
        ge      = (shifted >= {1'b0, r_den});
        n_rem   = ge ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
    end

    // control and datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.steps;
                r_rem  <= i_req.rem_init;
                r_dvd  <= i_req.dividend;
                r_den  <= i_req.divisor;
                r_quo  <= '0;
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_dvd <= {r_dvd[DIV_W-2:0], 1'b0};
                r_quo <= {r_quo[DIV_W-2:0], ge};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;
    assign o_rsp.rem  = r_rem;

endmodule

`default_nettype wire

FILE: tb/testbench.sv
// self-checking testbench for the keyframe track interpolator
`timescale 1ns / 100ps

module testbench;
    import kti_pkg::*;

    localparam int FRAC = 16;
    localparam longint FX_ONE = 64'sd65536;
    localparam longint FX_HALF = 64'sd32768;
    localparam int N_KEYS = 64;
    localparam int RANDOM_ITEMS = 600;
    // codes the package leaves out
    localparam logic [1:0] EXT_CLAMP = 2'd2;
    localparam logic [1:0] INTERP_LINEAR = 2'd0;

    typedef enum logic [1:0] {ROW_WORD, ROW_CFG, ROW_FILL} row_kind_e;

    typedef struct {
        row_kind_e  kind;
        logic [2:0] idx;
        logic [31:0] data;
        t_kti_in    w;
        bit         typed;
        t_kti_out   want;
    } stim_row_t;

    logic        i_clk, i_rst_n;
    logic        in_valid, in_ready, out_valid, out_ready, cfg_valid, cfg_ready;
    t_kti_in     in_word;
    t_kti_out    out_word;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;

    // track mirror and register mirror
    longint            trk_freq, trk_phase, trk_start, trk_stop;
    logic [1:0]        trk_extrap, trk_interp;
    int                trk_count, trk_hint;
    logic signed [31:0] trk_time [N_KEYS];
    logic signed [31:0] trk_val  [N_KEYS];
    logic signed [31:0] trk_fwd  [N_KEYS];
    logic signed [31:0] trk_bwd  [N_KEYS];

    t_kti_out  results_due [$];
    stim_row_t stim_rows [$];
    int  err_cnt = 0, burst_left = 0, n_queries = 0, n_writes = 0, n_cfg = 0;
    bit  cfg_phase = 0, hold_req = 0;

    keyframe_track_interpolator dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_ready(in_ready), .i_in_word(in_word),
        .o_out_valid(out_valid), .i_out_ready(out_ready), .o_out_word(out_word),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    // clock
    initial begin
        i_clk = 0;
        forever #1 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #4000000;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic longint sat32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint kt(int k);
        return longint'(trk_time[k]);
    endfunction

    function automatic void reset_track();
        trk_freq = FX_ONE; trk_phase = 0; trk_start = 0; trk_stop = 0;
        trk_extrap = EXT_CLAMP; trk_interp = INTERP_LINEAR;
        trk_count = 0; trk_hint = 0;
    endfunction

    function automatic void apply_cfg(logic [2:0] idx, logic [31:0] data);
        case (idx)
            CFG_FREQUENCY:  trk_freq = longint'($signed(data));
            CFG_PHASE:      trk_phase = longint'($signed(data));
            CFG_START_TIME: trk_start = longint'($signed(data));
            CFG_STOP_TIME:  trk_stop = longint'($signed(data));
            CFG_EXTRAP:     trk_extrap = data[1:0];
            CFG_INTERP:     trk_interp = data[1:0];
            CFG_KEY_COUNT: begin
                trk_count = int'(data[6:0]);
                if (trk_count > N_KEYS) trk_count = N_KEYS;
            end
            default: ;
        endcase
    endfunction

    // scale, offset and fold the query time into the active range
    function automatic longint map_query_time(longint raw);
        longint t, delta, d, q, r;
        t = sat32(((trk_freq * raw) >>> FRAC) + trk_phase);
        if (t >= trk_start && t <= trk_stop) return t;
        if (trk_extrap == EXT_CYCLIC || trk_extrap == EXT_REVERSE) begin
            delta = trk_stop - trk_start;
            if (delta <= 0) return trk_start;
            d = t - trk_start;
            q = d / delta;
            r = d % delta;
            if (r < 0) begin
                r += delta;
                q -= 1;
            end
            if (trk_extrap == EXT_CYCLIC || q[0] == 1'b0) return trk_start + r;
            return trk_stop - r;
        end
        if (t < trk_start) return trk_start;
        if (t > trk_stop) return trk_stop;
        return t;
    endfunction

    function automatic longint seg_fraction(longint num, longint den);
        longint x;
        if (den <= 0 || num <= 0) return 0;
        x = (num <<< FRAC) / den;
        return (x > FX_ONE) ? FX_ONE : x;
    endfunction

    // apply one input word to the mirror; a query yields its result word
    function automatic void track_eval(input t_kti_in w, output bit has_res,
                                       output t_kti_out r);
        longint t, x, v1, v2, val, x2, x3, tb, tf, acc;
        int n, lo, hi, i, j;
        r = '0;
        has_res = 0;
        if (w.kind == KIND_WRITE) begin
            trk_time[w.key_index] = w.key_time;
            trk_val[w.key_index]  = w.key_value;
            trk_fwd[w.key_index]  = w.key_forward;
            trk_bwd[w.key_index]  = w.key_backward;
            return;
        end
        has_res = 1;
        t = map_query_time(longint'($signed(w.query_time)));
        n = trk_count;
        r.mapped_time = t[31:0];
        if (n == 0) return;
        x = 0;
        if (t <= kt(0)) begin
            lo = 0; hi = 0;
        end else if (t >= kt(n - 1)) begin
            lo = n - 1; hi = n - 1;
        end else begin
            i = (trk_hint < n) ? trk_hint : 0;
            if (t > kt(i)) begin
                j = i + 1;
                while (j < n - 1 && t >= kt(j)) begin
                    i = j;
                    j++;
                end
                x = seg_fraction(t - kt(i), kt(j) - kt(i));
                lo = i; hi = j;
            end else if (t < kt(i)) begin
                j = i - 1;
                while (j > 0 && t <= kt(j)) begin
                    i = j;
                    j--;
                end
                x = FX_ONE - seg_fraction(kt(i) - t, kt(i) - kt(j));
                lo = j; hi = i;
            end else begin
                lo = i; hi = i;
            end
        end
        trk_hint = lo;
        v1 = longint'(trk_val[lo]);
        v2 = longint'(trk_val[hi]);
        if (trk_interp == INTERP_HERMITE) begin
            x2 = (x * x) >>> FRAC;
            x3 = (x2 * x) >>> FRAC;
            tb = longint'(trk_bwd[lo]);
            tf = longint'(trk_fwd[hi]);
            acc = v1 * (2 * x3 - 3 * x2 + FX_ONE) + v2 * (3 * x2 - 2 * x3)
                + tb * (x3 - 2 * x2 + x) + tf * (x3 - x2);
            val = sat32(acc >>> FRAC);
        end else if (trk_interp == INTERP_STEP) begin
            val = (x < FX_HALF) ? v1 : v2;
        end else begin
            val = sat32(v1 + (((v2 - v1) * x) >>> FRAC));
        end
        r.result_value = val[31:0];
        r.result_valid = 1'b1;
        r.lower_key = lo[5:0];
    endfunction

    // offer one word in bursts with random gaps, then record its result
    task automatic send_word(t_kti_in w, bit typed = 0, t_kti_out want = '0);
        bit has;
        t_kti_out r;
        int gap;
        if (cfg_phase) begin
            cfg_valid <= 1'b0;
            cfg_phase = 0;
        end
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        in_valid <= 1'b1;
        in_word <= w;
        do @(posedge i_clk); while (!in_ready);
        track_eval(w, has, r);
        if (w.kind == KIND_WRITE) n_writes++;
        else n_queries++;
        if (has) results_due.push_back(typed ? want : r);
    endtask

    // stop offering and let the block settle
    task automatic drain();
        in_valid <= 1'b0;
        burst_left = 0;
        while (results_due.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    // valid stays high across back-to-back writes; send_word drops it
    task automatic cfg_write(logic [2:0] idx, logic [31:0] data);
        if (!cfg_phase) begin
            drain();
            cfg_phase = 1;
        end
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge i_clk); while (!cfg_ready);
        apply_cfg(idx, data);
        n_cfg++;
    endtask

    function automatic t_kti_in query_word(logic [31:0] qt);
        t_kti_in w;
        w = t_kti_in'($urandom);
        w.key_time = $urandom;
        w.key_value = $urandom;
        w.kind = KIND_QUERY;
        w.query_time = qt;
        return w;
    endfunction

    function automatic logic [31:0] tangent_rand();
        if ($urandom_range(0, 1) == 0) return $urandom;
        return 32'($signed($urandom_range(0, 1 << 19)) - (1 << 18));
    endfunction

    // write keys 0..n-1, unit spacing or random ascending with some noise
    task automatic load_track(int n, bit unit_step);
        t_kti_in w;
        longint t;
        t = unit_step ? 0 : longint'($urandom_range(0, 1 << 25)) - (1 << 24);
        for (int k = 0; k < n; k++) begin
            w.kind = KIND_WRITE;
            w.key_index = k[5:0];
            w.key_time = t[31:0];
            if (!unit_step && $urandom_range(0, 19) == 0) w.key_time = $urandom;
            w.key_value = ($urandom_range(0, 3) == 0) ? $urandom
                        : 32'($signed($urandom_range(0, 1 << 24)) - (1 << 23));
            w.key_forward = tangent_rand();
            w.key_backward = tangent_rand();
            w.query_time = $urandom;
            send_word(w);
            t += unit_step ? FX_ONE : longint'($urandom_range(0, 1 << $urandom_range(4, 18)));
        end
    endtask

    function automatic void add_cfg(logic [2:0] idx, logic [31:0] data);
        stim_row_t s;
        s = '{kind: ROW_CFG, idx: idx, data: data, w: '0, typed: 0, want: '0};
        stim_rows.push_back(s);
    endfunction

    function automatic void add_query(logic [31:0] qt, bit typed = 0, t_kti_out want = '0);
        stim_row_t s;
        s = '{kind: ROW_WORD, idx: '0, data: '0, w: query_word(qt), typed: typed, want: want};
        stim_rows.push_back(s);
    endfunction

    function automatic void add_fill();
        stim_row_t s;
        s = '{kind: ROW_FILL, idx: '0, data: '0, w: '0, typed: 0, want: '0};
        stim_rows.push_back(s);
    endfunction

    function automatic void build_directed();
        t_kti_out empty_res;
        empty_res = '0;
        // empty track after reset: range [0,0] clamps everything to 0
        add_query(32'h7FFF_FFFF, 1, empty_res);
        add_query(32'h8000_0000, 1, empty_res);
        add_fill();
        add_cfg(CFG_KEY_COUNT, 32'd64);
        add_cfg(CFG_STOP_TIME, 32'd63 << 16);
        // linear: inside, end keys, forward and backward walks from the hint
        add_query((32'd10 << 16) + 32'h8000);
        add_query(32'd0);
        add_query(32'd63 << 16);
        add_query(32'd20 << 16);
        add_query(32'd20 << 16);
        add_query((32'd5 << 16) + 32'h4000);
        add_cfg(CFG_INTERP, {30'd0, INTERP_HERMITE});
        add_query(32'd478413);
        add_cfg(CFG_INTERP, {30'd0, INTERP_STEP});
        add_query((32'd7 << 16) + 32'h4000);
        add_query((32'd7 << 16) + 32'hC000);
        add_cfg(CFG_INTERP, 32'd3);
        add_query((32'd7 << 16) + 32'h8000);
        // wrap and mirror outside the range
        add_cfg(CFG_EXTRAP, {30'd0, EXT_CYCLIC});
        add_query(32'd70 << 16);
        add_query(-(32'd3 << 16));
        add_cfg(CFG_EXTRAP, {30'd0, EXT_REVERSE});
        add_query(32'd70 << 16);
        add_query(32'd130 << 16);
        add_cfg(CFG_EXTRAP, 32'd3);
        add_query(32'd100 << 16);
        // extreme scaling and offset, saturating
        add_cfg(CFG_FREQUENCY, 32'h8000_0000);
        add_query(32'h7FFF_FFFF);
        add_cfg(CFG_FREQUENCY, 32'h7FFF_FFFF);
        add_cfg(CFG_PHASE, 32'h7FFF_FFFF);
        add_query(32'h7FFF_FFFF);
        // inverted range, in clamp mode and then in cyclic mode
        add_cfg(CFG_FREQUENCY, 32'h0001_0000);
        add_cfg(CFG_PHASE, 32'd0);
        add_cfg(CFG_START_TIME, 32'd5 << 16);
        add_cfg(CFG_STOP_TIME, 32'd2 << 16);
        add_cfg(CFG_EXTRAP, {30'd0, EXT_CLAMP});
        add_query(32'd3 << 16);
        add_cfg(CFG_EXTRAP, {30'd0, EXT_CYCLIC});
        add_query(32'd9 << 16);
        // key count above the store size saturates
        add_cfg(CFG_KEY_COUNT, 32'd127);
        add_query(32'd40 << 16);
    endfunction

    function automatic logic [31:0] pick_extreme();
        case ($urandom_range(0, 3))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'd0;
            default: return 32'hFFFF_FFFF;
        endcase
    endfunction

    function automatic logic [31:0] clip32(longint v);
        longint s;
        s = sat32(v);
        return s[31:0];
    endfunction

    // registers for one random round, chosen around the current track
    task automatic random_setup();
        int n, c;
        longint lo, hi, q4;
        c = $urandom_range(0, 9);
        n = (c == 0) ? 0 : (c == 1) ? 1 : (c == 2) ? 2 : (c == 3) ? N_KEYS
          : (c == 4) ? $urandom_range(65, 127) : $urandom_range(3, 12);
        if ($urandom_range(0, 4) != 0 && n > 0) load_track((n > N_KEYS) ? N_KEYS : n, 0);
        cfg_write(CFG_KEY_COUNT, n);
        lo = (trk_count > 0) ? kt(0) : 0;
        hi = (trk_count > 0) ? kt(trk_count - 1) : 0;
        q4 = (hi - lo) / 4;
        cfg_write(CFG_FREQUENCY, ($urandom_range(0, 9) < 7) ? 32'h0001_0000
                  : ($urandom_range(0, 1) == 0) ? pick_extreme() : $urandom);
        cfg_write(CFG_PHASE, ($urandom_range(0, 9) < 7)
                  ? 32'($signed($urandom_range(0, 1 << 18)) - (1 << 17))
                  : ($urandom_range(0, 1) == 0) ? pick_extreme() : $urandom);
        case ($urandom_range(0, 5))
            0, 1: begin
                cfg_write(CFG_START_TIME, clip32(lo + q4));
                cfg_write(CFG_STOP_TIME, clip32(hi - q4));
            end
            2: begin
                cfg_write(CFG_START_TIME, clip32(lo - $urandom_range(0, 1 << 18)));
                cfg_write(CFG_STOP_TIME, clip32(hi + $urandom_range(0, 1 << 18)));
            end
            3: begin
                cfg_write(CFG_START_TIME, clip32(hi));
                cfg_write(CFG_STOP_TIME, clip32(lo));
            end
            4: begin
                cfg_write(CFG_START_TIME, 32'h8000_0000);
                cfg_write(CFG_STOP_TIME, 32'h7FFF_FFFF);
            end
            default: begin
                cfg_write(CFG_START_TIME, $urandom);
                cfg_write(CFG_STOP_TIME, $urandom);
            end
        endcase
        cfg_write(CFG_EXTRAP, $urandom_range(0, 3));
        cfg_write(CFG_INTERP, $urandom_range(0, 3));
    endtask

    function automatic logic [31:0] random_query_time();
        longint lo, hi, span;
        int c;
        lo = (trk_count > 0) ? kt(0) : trk_start;
        hi = (trk_count > 0) ? kt(trk_count - 1) : trk_stop;
        if (hi < lo) hi = lo;
        span = hi - lo + FX_ONE;
        c = $urandom_range(0, 99);
        if (c < 55)
            return clip32(lo - span / 2 + longint'({$urandom, $urandom} % (2 * span)));
        if (c < 70 && trk_count > 0)
            return trk_time[$urandom_range(0, trk_count - 1)];
        if (c < 90) return $urandom;
        return pick_extreme();
    endfunction

    // results: compare each word with the oldest expectation
    always @(posedge i_clk) begin
        t_kti_out want;
        if (i_rst_n && out_valid && out_ready) begin
            if (results_due.size() == 0) begin
                $error("result word with nothing expected: %h", out_word);
                err_cnt++;
            end else begin
                want = results_due.pop_front();
                if (out_word.result_value !== want.result_value) begin
                    $error("result_value exp %h got %h", want.result_value,
                           out_word.result_value);
                    err_cnt++;
                end
                if (out_word.result_valid !== want.result_valid) begin
                    $error("result_valid exp %b got %b", want.result_valid,
                           out_word.result_valid);
                    err_cnt++;
                end
                if (out_word.mapped_time !== want.mapped_time) begin
                    $error("mapped_time exp %h got %h", want.mapped_time,
                           out_word.mapped_time);
                    err_cnt++;
                end
                if (out_word.lower_key !== want.lower_key) begin
                    $error("lower_key exp %0d got %0d", want.lower_key,
                           out_word.lower_key);
                    err_cnt++;
                end
            end
        end
    end

    // receiver: stall patterns in segments, plus a long hold-off on request
    initial begin
        int style, seg_left, hold_cnt;
        style = 0; seg_left = 0; hold_cnt = 0;
        out_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_cnt > 0) begin
                hold_cnt--;
                out_ready <= 1'b0;
            end else if (hold_req) begin
                hold_req = 0;
                hold_cnt = 400;
                out_ready <= 1'b0;
            end else begin
                if (seg_left == 0) begin
                    style = $urandom_range(0, 3);
                    seg_left = $urandom_range(8, 64);
                end
                seg_left--;
                case (style)
                    0: out_ready <= 1'b1;
                    1: out_ready <= ~out_ready;
                    2: out_ready <= ($urandom_range(0, 3) != 0);
                    default: out_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // stimulus
    initial begin
        int items, rounds, nq;
        in_valid = 1'b0;
        in_word = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        i_rst_n = 1'b0;
        reset_track();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        build_directed();
        foreach (stim_rows[k]) begin
            case (stim_rows[k].kind)
                ROW_CFG:  cfg_write(stim_rows[k].idx, stim_rows[k].data);
                ROW_FILL: load_track(N_KEYS, 1);
                default:  send_word(stim_rows[k].w, stim_rows[k].typed, stim_rows[k].want);
            endcase
        end

        // random rounds
        items = 0;
        rounds = 0;
        while (items < RANDOM_ITEMS) begin
            random_setup();
            if (rounds == 2) hold_req = 1;
            nq = $urandom_range(15, 40);
            for (int k = 0; k < nq; k++) send_word(query_word(random_query_time()));
            items += nq + trk_count;
            rounds++;
        end

        drain();
        cfg_valid <= 1'b0;
        repeat (100) @(posedge i_clk);
        $display("covered %0d queries and %0d key writes over %0d random rounds,",
                 n_queries, n_writes, rounds);
        $display("with %0d register writes across all modes and extremes", n_cfg);
        if (err_cnt == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/kti_pkg.sv
rtl/core/kti_div.sv
rtl/core/keyframe_track_interpolator.sv
tb/testbench.sv
